@@ rtl/mnp_pkg.sv @@
// shared constants and control/status types of the midi note-on parser
`default_nettype none
package mnp_pkg;

   // key range that notes are folded into
   localparam logic [7:0] FIRST_KEY = 8'd48;
   localparam logic [7:0] KEY_COUNT = 8'd24;
   localparam logic [7:0] KEY_LAST  = FIRST_KEY + KEY_COUNT - 8'd1;
   localparam logic [7:0] OCTAVE    = 8'd12;

   // midi codes
   localparam logic [3:0] NO_COMMAND   = 4'hF;
   localparam logic [3:0] NO_CHANNEL   = 4'hF;
   localparam logic [7:0] NO_NOTE      = 8'hFF;
   localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
   localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
   localparam logic [3:0] ALL_CHANNELS = 4'd9;
   localparam logic [3:0] SYS_NIBBLE   = 4'hF;

   // register indexes
   localparam logic CSR_MY_CHANNEL = 1'b0;

   // controller to datapath
   typedef struct packed {
      logic take;       // byte accepted this cycle
      logic fold_step;  // move folded note one octave
      logic emit;       // load key into output register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;        // current byte completes a note-on for us
      logic fold_done;  // folded note is inside the key range
   } dp_status_type;

endpackage
`default_nettype wire

@@ rtl/mnp_ctrl.sv @@
// controller state machine of the midi note-on parser
`default_nettype none
module mnp_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  mnp_pkg::dp_status_type status,
   output mnp_pkg::ctrl_cmd_type  cmd
);
   import mnp_pkg::*;

   typedef enum logic {ST_IDLE, ST_FOLD} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // commands and next state
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && status.hit) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (!status.fold_done) begin
               cmd.fold_step = 1'b1;
            end else if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/mnp_dp.sv @@
// datapath of the midi note-on parser: running status, octave folding, output key
`default_nettype none
module mnp_dp (
   input  wire                    clock,
   input  wire                    reset,
   input  wire  [7:0]             rx_byte,
   input  wire  [3:0]             my_channel,
   input  mnp_pkg::ctrl_cmd_type  cmd,
   output mnp_pkg::dp_status_type status,
   output logic [5:0]             key_index
);
   import mnp_pkg::*;

   logic [3:0] command_ff, command_in;
   logic [3:0] channel_ff, channel_in;
   logic [7:0] pending_ff, pending_in;
   logic [7:0] fold_ff;
   logic [5:0] key_ff;
   logic [7:0] key_full;

   logic is_status, is_system, note_cmd, chan_ok, below, above;

   // byte decode
   assign is_status = rx_byte[7];
   assign is_system = (rx_byte[7:4] == SYS_NIBBLE);
   assign note_cmd  = (command_ff == CMD_NOTE_OFF) || (command_ff == CMD_NOTE_ON);
   assign chan_ok   = (channel_ff == my_channel) || (my_channel == ALL_CHANNELS);

   // velocity byte of an accepted note-on with nonzero velocity
   assign status.hit = !is_status && note_cmd && (pending_ff != NO_NOTE) && chan_ok &&
                       (command_ff == CMD_NOTE_ON) && (rx_byte != 8'd0);

   // running status update
   always_comb begin
      command_in = command_ff;
      channel_in = channel_ff;
      pending_in = pending_ff;
      if (is_status) begin
         if (!is_system) begin
            command_in = rx_byte[7:4];
            channel_in = rx_byte[3:0];
            pending_in = NO_NOTE;
         end
      end else if (note_cmd) begin
         if (pending_ff == NO_NOTE) begin
            pending_in = rx_byte;
         end else begin
            pending_in = NO_NOTE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff <= NO_COMMAND;
         channel_ff <= NO_CHANNEL;
         pending_ff <= NO_NOTE;
      end else if (cmd.take) begin
         command_ff <= command_in;
         channel_ff <= channel_in;
         pending_ff <= pending_in;
      end
   end

   // octave folding, one octave a cycle
   assign below            = (fold_ff < FIRST_KEY);
   assign above            = (fold_ff > KEY_LAST);
   assign status.fold_done = !below && !above;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         fold_ff <= {1'b0, pending_ff[6:0]};
      end else if (cmd.fold_step) begin
         fold_ff <= below ? (fold_ff + OCTAVE) : (fold_ff - OCTAVE);
      end
   end

   // output key register
   assign key_full = fold_ff - FIRST_KEY;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         key_ff <= key_full[5:0];
      end
   end

   assign key_index = key_ff;

endmodule
`default_nettype wire

@@ rtl/midi_note_on_parser.sv @@
// top level of the midi note-on parser with configuration register
//
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    tdata[7:0] rx_byte
//  rsp      out        rsp_tvalid/tready    tdata[5:0] key_index, [7:6] zero
//  csr      in         apb psel/penable     pwdata[3:0] my_channel at index 0
//
//  a byte that yields no key is taken; req_tready stays high after it
//  a note-on that yields a key closes req_tready; the fold loop moves the note one
//  octave per cycle into the key range, then the key goes to the output register
//  the output register holds one key; a stalled rsp side holds the fold
//  state until the register frees, then the block reopens for bytes
//  reset is synchronous, active high, and clears running status and my_channel
`default_nettype none
module midi_note_on_parser (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] key_index, [7:6] zero
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mnp_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic [3:0]    my_channel_ff;
   logic [5:0]    key_index;
   logic          csr_index;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         my_channel_ff <= 4'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_index == CSR_MY_CHANNEL)) begin
         my_channel_ff <= csr_pwdata[3:0];
      end
   end

   assign csr_prdata = (csr_index == CSR_MY_CHANNEL) ? {28'd0, my_channel_ff} : 32'd0;

   // controller
   mnp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   mnp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .rx_byte    (req_tdata),
      .my_channel (my_channel_ff),
      .cmd        (cmd),
      .status     (status),
      .key_index  (key_index)
   );

   assign rsp_tdata = {2'b00, key_index};

   // a shown key always lies inside the key range
   a_key_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({2'b00, rsp_tdata[5:0]} < KEY_COUNT))
      else $error("key index out of range");

   // a note-on hit closes the input while folding
   a_hit_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && status.hit) |=> !req_tready)
      else $error("input open after a note-on hit");

   // a byte that is no hit leaves the input open
   a_miss_open: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !status.hit) |=> req_tready)
      else $error("input closed after a byte without a key");

   // a key is emitted only out of a folded, in-range note
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.fold_done)
      else $error("key emitted before folding finished");

endmodule
`default_nettype wire

@@ test/midi_note_on_parser_test.sv @@
// self-checking testbench for the midi note-on parser: stream bytes in, check struck keys
`timescale 1ns / 1ps
`default_nettype none
module midi_note_on_parser_test;
   import mnp_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 16;     // fold loop plus emit, with margin
   localparam int GAP_PERCENT = 25;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // parser state as predicted
   logic [3:0]  listen_channel;
   logic [3:0]  run_command;
   logic [3:0]  run_channel;
   logic [7:0]  held_note;
   logic [5:0]  struck_keys[$];

   logic        gaps_on = 1'b1;
   int          error_count = 0;
   int          byte_count = 0;
   int          cycle_count = 0;

   midi_note_on_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [7:0] rx_byte
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [5:0] key_index, [7:6] zero
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("midi_note_on_parser regression: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // fold a note by octaves into the key range, return offset from first key
   function automatic logic [5:0] fold_to_key(input int note);
      int n;
      int lo;
      int hi;
      n  = note;
      lo = int'(FIRST_KEY);
      hi = int'(FIRST_KEY) + int'(KEY_COUNT) - 1;
      if (n < lo) n += int'(OCTAVE) * ((lo - n + int'(OCTAVE) - 1) / int'(OCTAVE));
      if (n > hi) n -= int'(OCTAVE) * ((n - hi + int'(OCTAVE) - 1) / int'(OCTAVE));
      n -= lo;
      if (n < 0) n = 0;
      return n[5:0];
   endfunction

   // running-status tracking for one accepted byte
   task automatic track_byte(input logic [7:0] b);
      logic taken;
      if (b[7]) begin
         if (b[7:4] != SYS_NIBBLE) begin
            run_command = b[7:4];
            run_channel = b[3:0];
            held_note   = NO_NOTE;
         end
      end else if (run_command == CMD_NOTE_ON || run_command == CMD_NOTE_OFF) begin
         if (held_note == NO_NOTE) begin
            held_note = b;
         end else begin
            taken = (run_channel == listen_channel) || (listen_channel == ALL_CHANNELS);
            if (taken && run_command == CMD_NOTE_ON && b != 8'd0)
               struck_keys.push_back(fold_to_key(int'(held_note[6:0])));
            held_note = NO_NOTE;
         end
      end
   endtask

   // present one item and wait for it to be taken
   task automatic send_byte(input logic [7:0] b);
      if (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      track_byte(b);
      if (b[7:4] != SYS_NIBBLE) byte_count++;
   endtask

   // wait until every key has come out and the block has gone quiet
   task automatic drain;
      req_tvalid <= 1'b0;
      while (struck_keys.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write the listening channel, then read it back
   task automatic set_channel(input logic [3:0] ch);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_MY_CHANNEL, 2'b00};
      csr_pwdata  <= {28'd0, ch};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      listen_channel = ch;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata != {28'd0, listen_channel})
         report_mismatch($sformatf("my_channel reads %0h, wrote %0h", csr_prdata, ch));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result side: random stalls, compare each key with the oldest expected one
   always @(posedge clock) begin
      logic [5:0] want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (struck_keys.size() == 0) begin
               report_mismatch($sformatf("unexpected key %0d", rsp_tdata[5:0]));
            end else begin
               want = struck_keys.pop_front();
               if (rsp_tdata[5:0] != want)
                  report_mismatch($sformatf("key_index %0d, expected %0d",
                                            rsp_tdata[5:0], want));
            end
         end
         rsp_tready <= !gaps_on || ($urandom_range(0, 99) >= GAP_PERCENT);
      end
   end

   // mostly well-formed note messages with running status, some noise
   task automatic random_traffic(input int count);
      int stop_at;
      int pairs;
      int kind;
      logic [3:0] ch;
      stop_at = byte_count + count;
      while (byte_count < stop_at) begin
         kind = $urandom_range(0, 99);
         ch = ($urandom_range(0, 1) == 0) ? listen_channel : 4'($urandom_range(0, 15));
         if (kind < 70) begin
            send_byte({($urandom_range(0, 3) == 0) ? CMD_NOTE_OFF : CMD_NOTE_ON, ch});
            pairs = $urandom_range(1, 4);
            repeat (pairs) begin
               send_byte(8'($urandom_range(0, 127)));
               if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(8'hF0, 8'hFF)));
               send_byte(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 127)));
            end
         end else if (kind < 85) begin
            send_byte(8'($urandom_range(0, 255)));
         end else if (kind < 95) begin
            send_byte({4'($urandom_range(4'hA, 4'hE)), ch});
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 127)));
         end else begin
            // message cut short by a new status
            send_byte({CMD_NOTE_ON, ch});
            send_byte(8'($urandom_range(0, 127)));
         end
      end
   endtask

   // extremes and each special case, on channel 0 after reset
   task automatic test_directed;
      logic [7:0] seq[$];
      seq = '{8'h3C, 8'h40,                       // data before any status
              8'hF0, 8'hF8, 8'hFF,                // system bytes
              8'h90, 8'h00, 8'h7F,                // lowest note, top velocity
              8'h7F, 8'h01,                       // running status, highest note
              8'h3C, 8'h00,                       // zero velocity
              8'h80, 8'h3C, 8'h40,                // note-off
              8'hB0, 8'h3C, 8'h40,                // other command
              8'h91, 8'h3C, 8'h40,                // wrong channel
              8'h90, 8'h3C, 8'hF8, 8'h40,         // real-time inside a message
              8'h90, 8'h47, 8'h9F, 8'h30, 8'h40,  // status cuts a pair
              8'hEF, 8'h2A, 8'h55};               // top channel command
      foreach (seq[i]) send_byte(seq[i]);
      drain();
   endtask

   // fixed listening channels, extremes included
   task automatic test_channel_sweep;
      logic [3:0] chans[$];
      chans = '{4'd15, ALL_CHANNELS, 4'd0, 4'd6};
      foreach (chans[i]) begin
         set_channel(chans[i]);
         random_traffic(240);
         drain();
      end
   endtask

   // no gaps on either side: input always valid, output always ready
   task automatic test_steady;
      gaps_on = 1'b0;
      set_channel(ALL_CHANNELS);
      random_traffic(200);
      drain();
      gaps_on = 1'b1;
   endtask

   // random listening channels
   task automatic test_random_channels;
      repeat (4) begin
         set_channel(4'($urandom_range(0, 15)));
         random_traffic(65);
         drain();
      end
   endtask

   initial begin
      listen_channel = 4'd0;
      run_command    = NO_COMMAND;
      run_channel    = NO_CHANNEL;
      held_note      = NO_NOTE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_channel_sweep();
      test_steady();
      test_random_channels();
      if (error_count == 0)
         $display("midi_note_on_parser regression: pass");
      else
         $display("midi_note_on_parser regression: fail");
      $finish;
   end

endmodule
`default_nettype wire
